[design/particle_grid_binning_counter_assert.svh]
// Assertion macros for the particle grid binning counter.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PARTICLE_GRID_BINNING_COUNTER_ASSERT_SVH
`define PARTICLE_GRID_BINNING_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

`define PGBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgbc: same-cycle check failed");

`define PGBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgbc: next-cycle check failed");

`else

`define PGBC_ASSERT_IMP(lbl, ante, cons)

`define PGBC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[design/pgbc_pkg.sv]
// Shared types and constants for the particle grid binning counter.
// No dependencies; imported by pgbc_axis and the top level, not by pgbc_cell_ram.
`default_nettype none

package pgbc_pkg;

    localparam int DEF_MAX_CELLS_PER_AXIS = 32;
    localparam int DEF_COUNT_WIDTH        = 16;

    localparam int ACTION_WIDTH      = 2;
    localparam int STATUS_WIDTH      = 2;
    localparam int COORD_WIDTH       = 32;
    localparam int CELL_IDX_WIDTH    = 5;
    localparam int OUT_COUNT_WIDTH   = 16;
    localparam int OOB_WIDTH         = 32;
    localparam int HALF_EXTENT_WIDTH = 31;
    localparam int INV_WIDTH         = 32;
    localparam int CELLS_WIDTH       = 6;
    localparam int MIN_COUNT_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH   = 2;
    localparam int CFG_DATA_WIDTH    = 32;
    localparam int SUM_WIDTH         = COORD_WIDTH + 1;

    localparam logic [ACTION_WIDTH-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR  = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_QUERY  = 2'd2;

    localparam logic [STATUS_WIDTH-1:0] STAT_BINNED  = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STAT_OOB     = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STAT_CLEARED = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] STAT_QUERY   = 2'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_EXTENT    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INV_CELL_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELLS_PER_AXIS = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_COUNT      = 2'd3;

    localparam logic [HALF_EXTENT_WIDTH-1:0] RST_HALF_EXTENT    = 31'd65536;
    localparam logic [INV_WIDTH-1:0]         RST_INV_CELL_WIDTH = 32'd65536;
    localparam logic [CELLS_WIDTH-1:0]       RST_CELLS_PER_AXIS = 6'd32;
    localparam logic [MIN_COUNT_WIDTH-1:0]   RST_MIN_COUNT      = 16'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_UPD
    } pgbc_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } pgbc_axis_ctl_t;

endpackage

`default_nettype wire

[design/pgbc_axis.sv]
// One axis of the binning datapath: offset add, then Q16.16 scale and floor.
// Depends on pgbc_pkg for widths and the control struct.
`default_nettype none

module pgbc_axis (
    input  wire logic                                      clk,
    input  wire pgbc_pkg::pgbc_axis_ctl_t                  ctl,
    input  wire logic signed [pgbc_pkg::COORD_WIDTH-1:0]   pos,
    input  wire logic [pgbc_pkg::HALF_EXTENT_WIDTH-1:0]    half_extent,
    input  wire logic [pgbc_pkg::INV_WIDTH-1:0]            inv_cell_width,
    output logic [pgbc_pkg::COORD_WIDTH-1:0]               index
);
    import pgbc_pkg::*;

    logic signed [SUM_WIDTH-1:0]          sum_reg;
    logic signed [SUM_WIDTH-1:0]          sum_next;
    logic [COORD_WIDTH-1:0]               index_reg;
    logic [COORD_WIDTH-1:0]               index_next;
    logic [COORD_WIDTH+INV_WIDTH-1:0]     product;
    logic                                 positive;

    assign sum_next = SUM_WIDTH'(pos) + $signed({2'b00, half_extent});

    // A sum at or below zero bins to index zero.
    assign positive = !sum_reg[SUM_WIDTH-1] && (|sum_reg[COORD_WIDTH-1:0]);
    assign product  = (COORD_WIDTH+INV_WIDTH)'(sum_reg[COORD_WIDTH-1:0])
                    * (COORD_WIDTH+INV_WIDTH)'(inv_cell_width);
    assign index_next = positive ? product[COORD_WIDTH+INV_WIDTH-1:INV_WIDTH] : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.step)
        begin
            index_reg <= index_next;
        end
    end

    assign index = index_reg;

endmodule

`default_nettype wire

[design/pgbc_cell_ram.sv]
// Cell count store: one write port and one read port, registered read data.
// Standalone; no package dependency.
`default_nettype none

module pgbc_cell_ram #(
    parameter int ADDR_WIDTH = 15,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_WIDTH-1:0] waddr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_WIDTH-1:0] raddr,
    output logic [DATA_WIDTH-1:0]      rdata
);
    logic [DATA_WIDTH-1:0] mem [2**ADDR_WIDTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/particle_grid_binning_counter.sv]
// Particle grid binning counter: a cubic histogram of particle positions held in one
// synchronous RAM with a per-cell saturating count, plus a saturating out-of-bounds total.
// Every request returns exactly one response. An insert passes the offset add, multiply,
// bounds check with RAM read, then count update with RAM write; a query skips the
// multiply. A new request is taken only once the last has responded, which the single
// cell RAM's read-modify-write requires. A clear request walks the RAM one entry per cycle
// over its 2^(3*ceil(log2(MAX_CELLS_PER_AXIS))) entries (32768 by default), then responds.
// The same clearing pass runs after reset, and no request is accepted until it ends.
// Configuration writes are accepted at any time and must only be issued while idle.
// Depends on pgbc_pkg, pgbc_axis, pgbc_cell_ram and the assertion macro header.
`default_nettype none

`include "particle_grid_binning_counter_assert.svh"

module particle_grid_binning_counter #(
    parameter int MAX_CELLS_PER_AXIS = pgbc_pkg::DEF_MAX_CELLS_PER_AXIS,
    parameter int COUNT_WIDTH        = pgbc_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,

    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [pgbc_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [pgbc_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,

    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic [pgbc_pkg::ACTION_WIDTH-1:0]        action,
    input  wire logic signed [pgbc_pkg::COORD_WIDTH-1:0]  pos_x,
    input  wire logic signed [pgbc_pkg::COORD_WIDTH-1:0]  pos_y,
    input  wire logic signed [pgbc_pkg::COORD_WIDTH-1:0]  pos_z,
    input  wire logic [pgbc_pkg::CELL_IDX_WIDTH-1:0]      cell_i,
    input  wire logic [pgbc_pkg::CELL_IDX_WIDTH-1:0]      cell_j,
    input  wire logic [pgbc_pkg::CELL_IDX_WIDTH-1:0]      cell_k,

    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic [pgbc_pkg::STATUS_WIDTH-1:0]             status,
    output logic [pgbc_pkg::CELL_IDX_WIDTH-1:0]           bin_i,
    output logic [pgbc_pkg::CELL_IDX_WIDTH-1:0]           bin_j,
    output logic [pgbc_pkg::CELL_IDX_WIDTH-1:0]           bin_k,
    output logic [pgbc_pkg::OUT_COUNT_WIDTH-1:0]          cell_count,
    output logic                                          cell_valid,
    output logic [pgbc_pkg::OOB_WIDTH-1:0]                oob_total
);
    import pgbc_pkg::*;

    localparam int AXW = $clog2(MAX_CELLS_PER_AXIS);
    localparam int AW  = 3 * AXW;
    localparam int NW  = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    pgbc_state_t state_reg;
    pgbc_state_t state_next;

    logic [HALF_EXTENT_WIDTH-1:0] half_extent_reg;
    logic [INV_WIDTH-1:0]         inv_cell_width_reg;
    logic [CELLS_WIDTH-1:0]       cells_per_axis_reg;
    logic [MIN_COUNT_WIDTH-1:0]   min_count_reg;

    logic [ACTION_WIDTH-1:0]      act_reg;
    logic [CELL_IDX_WIDTH-1:0]    cell_i_reg;
    logic [CELL_IDX_WIDTH-1:0]    cell_j_reg;
    logic [CELL_IDX_WIDTH-1:0]    cell_k_reg;
    logic [AW-1:0]                clr_addr_reg;
    logic [AW-1:0]                addr_reg;
    logic                         oob_hit_reg;
    logic                         q_outside_reg;
    logic [OOB_WIDTH-1:0]         oob_reg;

    logic                         out_valid_reg;
    logic [STATUS_WIDTH-1:0]      status_reg;
    logic [CELL_IDX_WIDTH-1:0]    bin_i_reg;
    logic [CELL_IDX_WIDTH-1:0]    bin_j_reg;
    logic [CELL_IDX_WIDTH-1:0]    bin_k_reg;
    logic [OUT_COUNT_WIDTH-1:0]   cell_count_reg;
    logic                         cell_valid_reg;
    logic [OOB_WIDTH-1:0]         oob_total_reg;

    pgbc_axis_ctl_t               axis_ctl;
    logic [COORD_WIDTH-1:0]       idx_x;
    logic [COORD_WIDTH-1:0]       idx_y;
    logic [COORD_WIDTH-1:0]       idx_z;

    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                mem_waddr;
    logic [COUNT_WIDTH-1:0]       mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [COUNT_WIDTH-1:0]       mem_rdata;

    logic                         emit;
    logic [NW-1:0]                cells_eff;
    logic                         ins_oob;
    logic                         q_outside;
    logic [AW-1:0]                ins_addr;
    logic [AW-1:0]                q_addr;
    logic [COUNT_WIDTH-1:0]       cnt_inc;

    logic [STATUS_WIDTH-1:0]      res_status;
    logic [CELL_IDX_WIDTH-1:0]    res_i;
    logic [CELL_IDX_WIDTH-1:0]    res_j;
    logic [CELL_IDX_WIDTH-1:0]    res_k;
    logic [COUNT_WIDTH-1:0]       res_cnt;
    logic                         res_has_cell;
    logic [OOB_WIDTH-1:0]         oob_after;
    logic [OUT_COUNT_WIDTH-1:0]   res_cnt_capped;
    logic                         res_valid;

    pgbc_axis u_axis_x (
        .clk            (clk),
        .ctl            (axis_ctl),
        .pos            (pos_x),
        .half_extent    (half_extent_reg),
        .inv_cell_width (inv_cell_width_reg),
        .index          (idx_x)
    );

    pgbc_axis u_axis_y (
        .clk            (clk),
        .ctl            (axis_ctl),
        .pos            (pos_y),
        .half_extent    (half_extent_reg),
        .inv_cell_width (inv_cell_width_reg),
        .index          (idx_y)
    );

    pgbc_axis u_axis_z (
        .clk            (clk),
        .ctl            (axis_ctl),
        .pos            (pos_z),
        .half_extent    (half_extent_reg),
        .inv_cell_width (inv_cell_width_reg),
        .index          (idx_z)
    );

    pgbc_cell_ram #(
        .ADDR_WIDTH (AW),
        .DATA_WIDTH (COUNT_WIDTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_extent_reg    <= RST_HALF_EXTENT;
            inv_cell_width_reg <= RST_INV_CELL_WIDTH;
            cells_per_axis_reg <= RST_CELLS_PER_AXIS;
            min_count_reg      <= RST_MIN_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HALF_EXTENT:    half_extent_reg    <= cfg_data[HALF_EXTENT_WIDTH-1:0];
                REG_INV_CELL_WIDTH: inv_cell_width_reg <= cfg_data[INV_WIDTH-1:0];
                REG_CELLS_PER_AXIS: cells_per_axis_reg <= cfg_data[CELLS_WIDTH-1:0];
                REG_MIN_COUNT:      min_count_reg      <= cfg_data[MIN_COUNT_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // A zero cell count acts as one, and counts above the store size act as the store size.
    always_comb
    begin
        if (cells_per_axis_reg == '0)
        begin
            cells_eff = NW'(1);
        end
        else if (32'(cells_per_axis_reg) > 32'(MAX_CELLS_PER_AXIS))
        begin
            cells_eff = NW'(MAX_CELLS_PER_AXIS);
        end
        else
        begin
            cells_eff = NW'(cells_per_axis_reg);
        end
    end

    assign ins_oob = (idx_x >= COORD_WIDTH'(cells_eff))
                  || (idx_y >= COORD_WIDTH'(cells_eff))
                  || (idx_z >= COORD_WIDTH'(cells_eff));
    assign ins_addr = {AXW'(idx_x), AXW'(idx_y), AXW'(idx_z)};

    assign q_outside = (32'(cell_i_reg) >= 32'(MAX_CELLS_PER_AXIS))
                    || (32'(cell_j_reg) >= 32'(MAX_CELLS_PER_AXIS))
                    || (32'(cell_k_reg) >= 32'(MAX_CELLS_PER_AXIS));
    assign q_addr = {AXW'(cell_i_reg), AXW'(cell_j_reg), AXW'(cell_k_reg)};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_addr_reg)
                begin
                    state_next = (act_reg == ACT_CLEAR) ? ST_UPD : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ACT_INSERT: state_next = ST_MUL;
                        ACT_CLEAR:  state_next = ST_CLEAR;
                        default:    state_next = ST_ADDR;
                    endcase
                end
            end
            ST_MUL:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_UPD;
            ST_UPD:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        axis_ctl = '0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        emit     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                axis_ctl.load = in_valid;
            end
            ST_MUL:
            begin
                axis_ctl.step = 1'b1;
            end
            ST_ADDR:
            begin
                mem_re = 1'b1;
            end
            ST_UPD:
            begin
                emit   = !out_valid_reg || out_ready;
                mem_we = emit && (act_reg == ACT_INSERT) && !oob_hit_reg;
            end
            default: ;
        endcase
    end

    assign mem_raddr = (act_reg == ACT_INSERT) ? ins_addr : q_addr;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : cnt_inc;

    assign cnt_inc = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);

    always_comb
    begin
        res_status   = STAT_QUERY;
        res_i        = '0;
        res_j        = '0;
        res_k        = '0;
        res_cnt      = '0;
        res_has_cell = 1'b0;
        oob_after    = oob_reg;
        case (act_reg)
            ACT_INSERT:
            begin
                if (oob_hit_reg)
                begin
                    res_status = STAT_OOB;
                    oob_after  = (&oob_reg) ? oob_reg : oob_reg + OOB_WIDTH'(1);
                end
                else
                begin
                    res_status   = STAT_BINNED;
                    res_i        = idx_x[CELL_IDX_WIDTH-1:0];
                    res_j        = idx_y[CELL_IDX_WIDTH-1:0];
                    res_k        = idx_z[CELL_IDX_WIDTH-1:0];
                    res_cnt      = cnt_inc;
                    res_has_cell = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                res_status = STAT_CLEARED;
            end
            default:
            begin
                res_status   = STAT_QUERY;
                res_i        = cell_i_reg;
                res_j        = cell_j_reg;
                res_k        = cell_k_reg;
                res_cnt      = q_outside_reg ? '0 : mem_rdata;
                res_has_cell = 1'b1;
            end
        endcase
    end

    assign res_cnt_capped = (32'(res_cnt) > 32'(16'hFFFF)) ? 16'hFFFF
                          : OUT_COUNT_WIDTH'(res_cnt);
    assign res_valid = res_has_cell && (32'(res_cnt) >= 32'(min_count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            act_reg       <= ACT_INSERT;
            clr_addr_reg  <= '0;
            oob_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (in_valid && in_ready)
            begin
                act_reg <= action;
                if (action == ACT_CLEAR)
                begin
                    oob_reg <= '0;
                end
            end
            if (emit)
            begin
                oob_reg       <= oob_after;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cell_i_reg <= cell_i;
            cell_j_reg <= cell_j;
            cell_k_reg <= cell_k;
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg      <= mem_raddr;
            oob_hit_reg   <= ins_oob;
            q_outside_reg <= q_outside;
        end
        if (emit)
        begin
            status_reg     <= res_status;
            bin_i_reg      <= res_i;
            bin_j_reg      <= res_j;
            bin_k_reg      <= res_k;
            cell_count_reg <= res_cnt_capped;
            cell_valid_reg <= res_valid;
            oob_total_reg  <= oob_after;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign bin_i      = bin_i_reg;
    assign bin_j      = bin_j_reg;
    assign bin_k      = bin_k_reg;
    assign cell_count = cell_count_reg;
    assign cell_valid = cell_valid_reg;
    assign oob_total  = oob_total_reg;

    `PGBC_ASSERT_IMP(a_ram_write_phase, mem_we, (state_reg == ST_CLEAR) || (state_reg == ST_UPD))
    `PGBC_ASSERT_IMP(a_cleared_zero, out_valid && (status == STAT_CLEARED), (oob_total == '0) && (cell_count == '0))
    `PGBC_ASSERT_IMP(a_binned_nonzero, out_valid && (status == STAT_BINNED), cell_count != '0)
    `PGBC_ASSERT_NEXT(a_emit_to_idle, emit, state_reg == ST_IDLE)

endmodule

`default_nettype wire
